### rtl/core/htfd_pkg.sv
// Package with the constants, payload types and CRC helper of the sensor frame decoder.
package htfd_pkg;

    localparam logic [7:0]  CrcSeed    = 8'hFF;
    localparam logic [7:0]  CrcPoly    = 8'h31;
    localparam logic [9:0]  HumScale   = 10'd1000;
    localparam logic [10:0] TempScale  = 11'd2000;
    localparam logic [11:0] TempOffset = 12'd500;
    localparam int          RawWidth   = 20;

    localparam logic [2:0] PosStatus = 3'd0;
    localparam logic [2:0] PosHumHi  = 3'd1;
    localparam logic [2:0] PosHumMid = 3'd2;
    localparam logic [2:0] PosSplit  = 3'd3;
    localparam logic [2:0] PosTempHi = 3'd4;
    localparam logic [2:0] PosTempLo = 3'd5;
    localparam logic [2:0] PosCrc    = 3'd6;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         status_byte;
        logic [19:0]        humidity_raw;
        logic [19:0]        temperature_raw;
        logic [9:0]         humidity_tenths;
        logic signed [11:0] temperature_tenths;
        logic [7:0]         crc_computed;
        logic [7:0]         crc_received;
        logic               crc_ok;
    } t_out_item;

    // Byte-wide MSB-first CRC-8 update.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/htfd_if.sv
// Valid/ready channel interfaces for the frame byte input and the decoded result output.
interface htfd_in_if;
    logic               valid;
    logic               ready;
    htfd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htfd_out_if;
    logic                valid;
    logic                ready;
    htfd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/humidity_temp_frame_decoder.sv
// Sensor frame decoder: a byte per cycle when not stalled, CRC-8 check, scaled readings.
// A result appears in the cycle after the CRC byte (byte 6) is accepted.
// Throughput: one byte per cycle unless a held result is not taken; the single output
// register accepts a new byte while its result is taken in the same cycle.
// Reset: synchronous, active low; clears the byte position, seeds the CRC with 0xFF and
// empties the output register.
module humidity_temp_frame_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    htfd_in_if.sink           i_byte,
    htfd_out_if.source        o_result
);

    logic [2:0]           r_pos,     n_pos;
    logic [7:0]           r_crc,     n_crc;
    logic [7:0]           r_status,  n_status;
    logic [19:0]          r_hum,     n_hum;
    logic [19:0]          r_temp,    n_temp;
    logic                 r_out_valid, n_out_valid;
    htfd_pkg::t_out_item  r_out,     n_out;

    logic        accept_in;
    logic [2:0]  pos;
    logic [7:0]  b;
    logic [7:0]  crc_fed;
    logic [29:0] hum_prod;
    logic [30:0] temp_prod;

    assign i_byte.ready    = !r_out_valid || o_result.ready;
    assign accept_in       = i_byte.valid && i_byte.ready;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out;

    assign b         = i_byte.data.frame_byte;
    assign pos       = (i_byte.data.frame_start || r_pos > htfd_pkg::PosCrc)
                       ? htfd_pkg::PosStatus : r_pos;
    assign crc_fed   = htfd_pkg::crc8_feed(
                           (pos == htfd_pkg::PosStatus) ? htfd_pkg::CrcSeed : r_crc, b);
    assign hum_prod  = r_hum * htfd_pkg::HumScale;
    assign temp_prod = r_temp * htfd_pkg::TempScale;

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_status    = r_status;
        n_hum       = r_hum;
        n_temp      = r_temp;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        if (accept_in) begin
            n_pos = pos + 3'd1;
            unique case (pos)
                htfd_pkg::PosStatus: begin
                    n_status = b;
                    n_crc    = crc_fed;
                    n_hum    = '0;
                    n_temp   = '0;
                end
                htfd_pkg::PosHumHi: begin
                    n_crc = crc_fed;
                    n_hum = {b, 12'd0};
                end
                htfd_pkg::PosHumMid: begin
                    n_crc = crc_fed;
                    n_hum = r_hum | {8'd0, b, 4'd0};
                end
                htfd_pkg::PosSplit: begin
                    n_crc  = crc_fed;
                    n_hum  = r_hum | {16'd0, b[7:4]};
                    n_temp = {b[3:0], 16'd0};
                end
                htfd_pkg::PosTempHi: begin
                    n_crc  = crc_fed;
                    n_temp = r_temp | {4'd0, b, 8'd0};
                end
                htfd_pkg::PosTempLo: begin
                    n_crc  = crc_fed;
                    n_temp = r_temp | {12'd0, b};
                end
                default: begin
                    n_pos                    = htfd_pkg::PosStatus;
                    n_crc                    = htfd_pkg::CrcSeed;
                    n_out_valid              = 1'b1;
                    n_out.status_byte        = r_status;
                    n_out.humidity_raw       = r_hum;
                    n_out.temperature_raw    = r_temp;
                    n_out.humidity_tenths    = hum_prod[29:htfd_pkg::RawWidth];
                    n_out.temperature_tenths = $signed({1'b0, temp_prod[30:htfd_pkg::RawWidth]}
                                                       - htfd_pkg::TempOffset);
                    n_out.crc_computed       = r_crc;
                    n_out.crc_received       = b;
                    n_out.crc_ok             = (r_crc == b);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= htfd_pkg::PosStatus;
            r_crc       <= htfd_pkg::CrcSeed;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hum    <= n_hum;
        r_temp   <= n_temp;
        r_out    <= n_out;
    end

endmodule
